/* rtl/core/pac_pkg.sv */
// ----------------------------------------------------------------------------
// pac_pkg - shared types and constants of the periodic affine cipher
// Holds the status codes, register indexes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pac_pkg;

	localparam int unsigned CharW       = 8;
	localparam int unsigned ProdW       = 2 * CharW;
	localparam int unsigned BitsPerStep = 2;
	localparam int unsigned ModSteps    = ProdW / BitsPerStep;
	localparam int unsigned StepCntW    = $clog2(ModSteps);
	localparam int unsigned CfgIdxW     = 3;
	localparam int unsigned PreSlots    = 4;
	localparam int unsigned PreIdxW     = $clog2(PreSlots);

	localparam logic [CharW-1:0] LETTER_BASE  = 8'h41;
	localparam logic [CharW-1:0] NEWLINE_CODE = 8'h0A;

	// register indexes of the write port
	localparam logic [CfgIdxW-1:0] CFG_MODE        = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_MODULUS     = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_MULT_FIRST  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_MULT_SECOND = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_OFFSET_EVEN = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_OFFSET_ODD  = 3'd5;

	// slots reduced modulo m after every configuration change
	localparam logic [PreIdxW-1:0] PRE_MULT_FIRST  = 2'd0;
	localparam logic [PreIdxW-1:0] PRE_MULT_SECOND = 2'd1;
	localparam logic [PreIdxW-1:0] PRE_OFFSET_EVEN = 2'd2;
	localparam logic [PreIdxW-1:0] PRE_OFFSET_ODD  = 2'd3;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_NOINV = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_PRE_LOAD,
		ST_PRE_STEP,
		ST_PRE_STORE,
		ST_SRCH_INIT,
		ST_SRCH,
		ST_IDLE,
		ST_CHECK,
		ST_REDUCE,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic               char_load;
		logic               chk_take;
		logic               phase_clear;
		logic               mod_load_pre;
		logic               mod_load_prod;
		logic               mod_step;
		logic               pre_store;
		logic [PreIdxW-1:0] pre_idx;
		logic               srch_init;
		logic               srch_step;
		logic               out_load;
	} pac_cmd_t;

	typedef struct packed {
		logic    newline;
		status_t kind;
		logic    srch_last;
	} pac_sts_t;

	// one restoring step: bring a value below 2m back below m
	function automatic logic [CharW-1:0] mod_sub(input logic [CharW:0] t,
		input logic [CharW-1:0] m);
		logic [CharW:0] diff;
		diff = t - {1'b0, m};
		if (t >= {1'b0, m}) begin
			mod_sub = diff[CharW-1:0];
		end else begin
			mod_sub = t[CharW-1:0];
		end
	endfunction

endpackage

/* rtl/core/periodic_affine_cipher.sv */
// ----------------------------------------------------------------------------
// periodic_affine_cipher - affine cipher with a four-phase periodic key
// Encrypts or decrypts one character per request over an alphabet of m
// letters starting at 'A'; newline resets the key phase and emits nothing.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   s_*       in          s_tvalid/s_tready    s_tdata = in_char
//   m_*       out         m_tvalid/m_tready    m_tdata = out_char, m_tuser = status
//   cfg_*     in          cfg_we (no wait)     cfg_index, cfg_data
//
// Steps: a valid character passes through check, 8 remainder steps at two
// bits each, and emit; an invalid one goes from check to emit, and a newline
// from check back to idle. No request is accepted until the last is done.
// The shift-subtract remainder unit is shared with key preparation.
// Reset and every register write start key preparation: four values reduced
// modulo m, then an inverse search over the residues below m; s_tready stays
// low throughout. Stalls: the result register frees the input side; a held
// result blocks only the emit step of the following character.
module periodic_affine_cipher (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] in_char
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] out_char
	output logic [1:0]                    m_tuser,   // [1:0] status
	input  logic                          cfg_we,
	input  logic [pac_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pac_pkg::CharW-1:0]     cfg_data
);

	pac_pkg::pac_cmd_t cmd;
	pac_pkg::pac_sts_t sts;
	pac_pkg::status_t  out_status;

	// controller: sequencing, request and result handshakes
	pac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: registers, key preparation, multiply and reduce
	pac_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.char_in    (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_char   (m_tdata),
		.out_status (out_status)
	);

	assign m_tuser = out_status;

	// one request in flight: no back-to-back acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	// a register write must restart key preparation
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("request accepted right after a register write");

	// error results carry a zero character
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != pac_pkg::STATUS_OK)) |-> (m_tdata == 8'h00))
		else $error("error result with nonzero character");

	// only defined status codes leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == pac_pkg::STATUS_OK) || (m_tuser == pac_pkg::STATUS_RANGE)
			|| (m_tuser == pac_pkg::STATUS_NOINV)))
		else $error("undefined status code on result");

endmodule

/* rtl/core/pac_mod.sv */
// ----------------------------------------------------------------------------
// pac_mod - shift-subtract remainder unit
// Reduces a 16-bit value modulo an 8-bit modulus, two bits per step.
// ----------------------------------------------------------------------------
module pac_mod (
	input  logic                       clk,
	input  logic                       load,
	input  logic [pac_pkg::ProdW-1:0]  load_val,
	input  logic                       step,
	input  logic [pac_pkg::CharW-1:0]  modulus,
	output logic [pac_pkg::CharW-1:0]  rem
);

	logic [pac_pkg::ProdW-1:0] val_q;
	logic [pac_pkg::CharW-1:0] rem_q;
	logic [pac_pkg::CharW-1:0] rem_next;

	always_comb begin
		rem_next = rem_q;
		for (int k = 0; k < pac_pkg::BitsPerStep; k++) begin
			rem_next = pac_pkg::mod_sub({rem_next, val_q[pac_pkg::ProdW-1-k]}, modulus);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= load_val;
			rem_q <= '0;
		end else if (step) begin
			val_q <= val_q << pac_pkg::BitsPerStep;
			rem_q <= rem_next;
		end
	end

	assign rem = rem_q;

endmodule

/* rtl/core/pac_dp.sv */
// ----------------------------------------------------------------------------
// pac_dp - cipher datapath
// Configuration registers, reduced key values, inverse search, key phase,
// the multiplier and the result register.
// ----------------------------------------------------------------------------
module pac_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pac_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pac_pkg::CharW-1:0]    cfg_data,
	input  logic [pac_pkg::CharW-1:0]    char_in,
	input  pac_pkg::pac_cmd_t            cmd,
	output pac_pkg::pac_sts_t            sts,
	output logic [pac_pkg::CharW-1:0]    out_char,
	output pac_pkg::status_t             out_status
);

	localparam int unsigned W = pac_pkg::CharW;

	logic         mode_q;
	logic [W-1:0] modulus_q;
	logic [W-1:0] mult_first_q;
	logic [W-1:0] mult_second_q;
	logic [W-1:0] offset_even_q;
	logic [W-1:0] offset_odd_q;

	logic [1:0]   phase_q;
	logic [W-1:0] char_q;
	pac_pkg::status_t kind_q;

	logic [W-1:0] mred_q  [2];
	logic [W-1:0] ored_q  [2];
	logic [W-1:0] inv_q   [2];
	logic [W-1:0] acc_q   [2];
	logic [W-1:0] acc_next[2];
	logic         found_q [2];
	logic         inv_ok_q[2];
	logic [W-1:0] srch_i_q;

	logic [W-1:0] out_char_q;
	pac_pkg::status_t out_status_q;

	logic [W-1:0]               pre_val;
	logic [W-1:0]               x;
	logic [W-1:0]               b;
	logic [W-1:0]               d;
	logic [W:0]                 d_wrap;
	logic [W-1:0]               op_a;
	logic [W-1:0]               op_b;
	logic [W-1:0]               addend;
	logic [pac_pkg::ProdW-1:0]  prod;
	logic [pac_pkg::ProdW-1:0]  mod_val;
	logic [W-1:0]               rem;
	logic                       sel;
	logic                       out_range;
	logic [W:0]                 letter_sum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= 1'b0;
			modulus_q     <= 8'd26;
			mult_first_q  <= 8'd1;
			mult_second_q <= 8'd1;
			offset_even_q <= 8'd0;
			offset_odd_q  <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pac_pkg::CFG_MODE:        mode_q        <= cfg_data[0];
				pac_pkg::CFG_MODULUS:     modulus_q     <= cfg_data;
				pac_pkg::CFG_MULT_FIRST:  mult_first_q  <= cfg_data;
				pac_pkg::CFG_MULT_SECOND: mult_second_q <= cfg_data;
				pac_pkg::CFG_OFFSET_EVEN: offset_even_q <= cfg_data;
				pac_pkg::CFG_OFFSET_ODD:  offset_odd_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.pre_idx)
			pac_pkg::PRE_MULT_FIRST:  pre_val = mult_first_q;
			pac_pkg::PRE_MULT_SECOND: pre_val = mult_second_q;
			pac_pkg::PRE_OFFSET_EVEN: pre_val = offset_even_q;
			pac_pkg::PRE_OFFSET_ODD:  pre_val = offset_odd_q;
			default:                  pre_val = mult_first_q;
		endcase
	end

	// classify the held character and form the product to reduce
	assign sel       = phase_q[1];
	assign x         = char_q - pac_pkg::LETTER_BASE;
	assign out_range = (char_q < pac_pkg::LETTER_BASE) || (x >= modulus_q);
	assign b         = ored_q[phase_q[0]];
	assign d_wrap    = ({1'b0, x} + {1'b0, modulus_q}) - {1'b0, b};
	assign d         = (x >= b) ? (x - b) : d_wrap[W-1:0];
	assign op_a      = mode_q ? inv_q[sel] : mred_q[sel];
	assign op_b      = mode_q ? d : x;
	assign addend    = mode_q ? '0 : b;
	assign prod      = ({{W{1'b0}}, op_a} * {{W{1'b0}}, op_b}) + {{W{1'b0}}, addend};
	assign mod_val   = cmd.mod_load_prod ? prod : {{W{1'b0}}, pre_val};

	always_comb begin
		sts.newline   = (char_q == pac_pkg::NEWLINE_CODE);
		sts.srch_last = (modulus_q < 8'd2) || (srch_i_q == (modulus_q - 8'd1));
		if (out_range) begin
			sts.kind = pac_pkg::STATUS_RANGE;
		end else if (!inv_ok_q[sel]) begin
			sts.kind = pac_pkg::STATUS_NOINV;
		end else begin
			sts.kind = pac_pkg::STATUS_OK;
		end
	end

	pac_mod u_mod (
		.clk      (clk),
		.load     (cmd.mod_load_pre | cmd.mod_load_prod),
		.load_val (mod_val),
		.step     (cmd.mod_step),
		.modulus  (modulus_q),
		.rem      (rem)
	);

	// store reduced multipliers and offsets
	always_ff @(posedge clk) begin
		if (cmd.pre_store) begin
			unique case (cmd.pre_idx)
				pac_pkg::PRE_MULT_FIRST:  mred_q[0] <= rem;
				pac_pkg::PRE_MULT_SECOND: mred_q[1] <= rem;
				pac_pkg::PRE_OFFSET_EVEN: ored_q[0] <= rem;
				pac_pkg::PRE_OFFSET_ODD:  ored_q[1] <= rem;
				default: ;
			endcase
		end
	end

	// inverse search: walk i over the residues, acc tracks a*i mod m
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			acc_next[k] = pac_pkg::mod_sub({1'b0, acc_q[k]} + {1'b0, mred_q[k]}, modulus_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			srch_i_q <= '0;
			for (int k = 0; k < 2; k++) begin
				acc_q[k]   <= '0;
				found_q[k] <= 1'b0;
				inv_q[k]   <= '0;
			end
		end else if (cmd.srch_step) begin
			srch_i_q <= srch_i_q + 8'd1;
			for (int k = 0; k < 2; k++) begin
				acc_q[k] <= acc_next[k];
				if ((acc_q[k] == 8'd1) && !found_q[k]) begin
					found_q[k] <= 1'b1;
					inv_q[k]   <= srch_i_q;
				end
				if (sts.srch_last) begin
					inv_ok_q[k] <= found_q[k] || (acc_q[k] == 8'd1) || (modulus_q == 8'd1);
				end
			end
		end
	end

	// request and result payload
	assign letter_sum = {1'b0, pac_pkg::LETTER_BASE} + {1'b0, rem};

	always_ff @(posedge clk) begin
		if (cmd.char_load) begin
			char_q <= char_in;
		end
		if (cmd.chk_take) begin
			kind_q <= sts.kind;
		end
		if (cmd.out_load) begin
			out_status_q <= kind_q;
			if (kind_q == pac_pkg::STATUS_OK) begin
				out_char_q <= letter_sum[W-1:0];
			end else begin
				out_char_q <= '0;
			end
		end
	end

	// key phase: clear on newline, advance on a good result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
		end else if (cmd.phase_clear) begin
			phase_q <= 2'd0;
		end else if (cmd.out_load && (kind_q == pac_pkg::STATUS_OK)) begin
			phase_q <= phase_q + 2'd1;
		end
	end

	assign out_char   = out_char_q;
	assign out_status = out_status_q;

endmodule

/* rtl/core/pac_ctrl.sv */
// ----------------------------------------------------------------------------
// pac_ctrl - cipher controller
// Sequences key reduction and inverse search after reset or a register
// write, then checks each request, reduces good ones, emits all but newline.
// ----------------------------------------------------------------------------
module pac_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                m_tready,
	output logic                m_tvalid,
	input  pac_pkg::pac_sts_t   sts,
	output pac_pkg::pac_cmd_t   cmd
);

	pac_pkg::ctrl_state_t state_q;
	pac_pkg::ctrl_state_t state_d;

	logic [pac_pkg::StepCntW-1:0] cnt_q;
	logic [pac_pkg::PreIdxW-1:0]  idx_q;
	logic                         m_tvalid_q;
	logic                         step_last;
	logic                         out_free;

	assign step_last = (cnt_q == pac_pkg::StepCntW'(pac_pkg::ModSteps - 1));
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pac_pkg::ST_PRE_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		cmd.pre_idx = idx_q;
		unique case (state_q)
			pac_pkg::ST_PRE_LOAD: begin
				cmd.mod_load_pre = 1'b1;
				state_d = pac_pkg::ST_PRE_STEP;
			end
			pac_pkg::ST_PRE_STEP: begin
				cmd.mod_step = 1'b1;
				if (step_last) begin
					state_d = pac_pkg::ST_PRE_STORE;
				end
			end
			pac_pkg::ST_PRE_STORE: begin
				cmd.pre_store = 1'b1;
				if (idx_q == pac_pkg::PreIdxW'(pac_pkg::PreSlots - 1)) begin
					state_d = pac_pkg::ST_SRCH_INIT;
				end else begin
					state_d = pac_pkg::ST_PRE_LOAD;
				end
			end
			pac_pkg::ST_SRCH_INIT: begin
				cmd.srch_init = 1'b1;
				state_d = pac_pkg::ST_SRCH;
			end
			pac_pkg::ST_SRCH: begin
				cmd.srch_step = 1'b1;
				if (sts.srch_last) begin
					state_d = pac_pkg::ST_IDLE;
				end
			end
			pac_pkg::ST_IDLE: begin
				s_tready = !cfg_we;
				if (s_tvalid && !cfg_we) begin
					cmd.char_load = 1'b1;
					state_d = pac_pkg::ST_CHECK;
				end
			end
			pac_pkg::ST_CHECK: begin
				cmd.chk_take = 1'b1;
				if (sts.newline) begin
					cmd.phase_clear = 1'b1;
					state_d = pac_pkg::ST_IDLE;
				end else if (sts.kind == pac_pkg::STATUS_OK) begin
					cmd.mod_load_prod = 1'b1;
					state_d = pac_pkg::ST_REDUCE;
				end else begin
					state_d = pac_pkg::ST_EMIT;
				end
			end
			pac_pkg::ST_REDUCE: begin
				cmd.mod_step = 1'b1;
				if (step_last) begin
					state_d = pac_pkg::ST_EMIT;
				end
			end
			pac_pkg::ST_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = pac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pac_pkg::ST_PRE_LOAD;
			end
		endcase
		// any register write restarts the key preparation
		if (cfg_we) begin
			state_d = pac_pkg::ST_PRE_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.mod_load_pre || cmd.mod_load_prod) begin
				cnt_q <= '0;
			end else if (cmd.mod_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cfg_we) begin
				idx_q <= '0;
			end else if (cmd.pre_store) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule
